// ----- design/pli_pkg.sv -----
// Shared constants, codes and types of the piecewise linear interpolator.
package pli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 7;
  localparam int DATA_W      = 32;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int QUOT_W      = 41;
  localparam int SUM_W       = QUOT_W + 2;
  localparam int MUL_STEPS   = DIFF_W;
  localparam int DIV_STEPS   = PROD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_INTERP = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_ZERO_WIDTH = 2'd2,
    ST_SAT        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_T0,
    S_SCAN,
    S_DIFF,
    S_MD,
    S_SUM,
    S_RDATA,
    S_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] a;
    logic [DIFF_W-1:0] b;
    logic [DIFF_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic              big;
    logic [QUOT_W-1:0] quot;
  } md_rsp_t;

endpackage

// ----- design/pli_if.sv -----
// Valid/ready channel interfaces for interpolator commands and results.
interface pli_cmd_if import pli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [ADDR_W-1:0]        entry_index;
  logic signed [DATA_W-1:0] entry_time;
  logic signed [DATA_W-1:0] entry_value;
  logic signed [DATA_W-1:0] query_time;

  modport source (output valid, func, entry_index, entry_time, entry_value, query_time,
                  input ready);
  modport sink   (input valid, func, entry_index, entry_time, entry_value, query_time,
                  output ready);
endinterface

interface pli_res_if import pli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic signed [DATA_W-1:0] result_time;
  logic [1:0]               status;

  modport source (output valid, result_value, result_time, status, input ready);
  modport sink   (input valid, result_value, result_time, status, output ready);
endinterface

// ----- design/pli_muldiv.sv -----
// Iterative unit: shift-add product of two magnitudes, then restoring division.
module pli_muldiv import pli_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  md_state_t         state, state_next;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] mcand;
  logic [DIFF_W-1:0] mplier;
  logic [DIFF_W-1:0] divisor;
  logic [DIFF_W-1:0] rem;
  logic [STEP_W-1:0] cnt;
  logic [DIFF_W:0]   shifted;
  logic [DIFF_W:0]   trial;
  logic              fits;

  assign shifted = {rem, acc[PROD_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: if (req.start) state_next = MD_MUL;
      MD_MUL:  if (cnt == '0) state_next = MD_DIV;
      MD_DIV:  if (cnt == '0) state_next = MD_DONE;
      MD_DONE: state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == MD_DONE);
    rsp.quot = acc[QUOT_W-1:0];
    // quotient above 2^40 counts as overflow
    rsp.big  = (|acc[PROD_W-1:QUOT_W]) || (acc[QUOT_W-1] && (|acc[QUOT_W-2:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (req.start) begin
          mcand   <= {{(PROD_W-DIFF_W){1'b0}}, req.a};
          mplier  <= req.b;
          divisor <= req.d;
          acc     <= '0;
          rem     <= '0;
          cnt     <= STEP_W'(MUL_STEPS - 1);
        end
      end
      MD_MUL: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[DIFF_W-1:1]};
        cnt    <= (cnt == '0) ? STEP_W'(DIV_STEPS - 1) : cnt - STEP_W'(1);
      end
      MD_DIV: begin
        // shift the product out into the remainder, quotient bits in behind
        rem <= fits ? trial[DIFF_W-1:0] : shifted[DIFF_W-1:0];
        acc <= {acc[PROD_W-2:0], fits};
        cnt <= cnt - STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == MD_IDLE)
    else $error("muldiv started while busy");

  a_nonzero_div: assert property (@(posedge clk) disable iff (rst)
    (req.start && state == MD_IDLE) |-> req.d != '0)
    else $error("muldiv started with zero divisor");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == MD_DIV |-> rem < divisor)
    else $error("division remainder out of range");

endmodule

// ----- design/piecewise_linear_interpolator.sv -----
// Top level: breakpoint table, scan sequencer and result register.
//
//   channel   dir   handshake          payload
//   cmd       in    valid/ready        func, entry_index, entry_time, entry_value, query_time
//   res       out   valid/ready        result_value, result_time, status
//   cfg       in    cfg_wr_en          cfg_wr_data (entry_count)
//
// Write goes from acceptance straight to S_EMIT; an in-range read passes S_RDATA first.
// Interpolate runs S_T0, S_SCAN, S_DIFF, S_MD and S_SUM, its length set by the k entries read
// by the scan (1 to n - 1, n = min(entry_count, 64)) one entry per cycle, and pli_muldiv's
// 33-step multiply plus 66-step divide; zero width ends at S_DIFF, one entry at S_T0.
// cmd is taken only between transactions; a finished result sits in the output
// register while the next transaction is accepted and worked on.
// Synchronous reset clears control and entry_count; the table needs no clearing.
module piecewise_linear_interpolator import pli_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  pli_cmd_if.sink            cmd,
  pli_res_if.source          res
);

  ctrl_state_t              state, state_next;
  logic [COUNT_W-1:0]       entry_count;
  logic [COUNT_W-1:0]       n_use;
  logic [2*DATA_W-1:0]      mem [TABLE_DEPTH];
  logic [2*DATA_W-1:0]      rd_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     mem_we;
  logic signed [DATA_W-1:0] rd_t, rd_v;
  logic signed [DATA_W-1:0] qt, prev_t, prev_v, cur_t, cur_v, av;
  logic signed [DATA_W-1:0] at_sel, av_sel;
  logic                     qle, anchor_cur, neg, big;
  logic [ADDR_W-1:0]        ai;
  logic [QUOT_W-1:0]        quot;
  logic [DIFF_W-1:0]        dt, dv, dq;
  logic signed [SUM_W-1:0]  av_x, q_x, sum;
  logic                     sum_ovf;
  logic                     scan_last, scan_stop;
  logic                     cmd_acc, load_out;
  func_t                    cmd_func;
  logic [DATA_W-1:0]        pend_value, pend_time;
  status_t                  pend_status;
  logic                     out_valid;
  logic [DATA_W-1:0]        out_value, out_time;
  status_t                  out_status;
  md_req_t                  md_req;
  md_rsp_t                  md_rsp;

  function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] x);
    return x[DIFF_W-1] ? (~x + DIFF_W'(1)) : x;
  endfunction

  pli_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign n_use    = (entry_count > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : entry_count;
  assign cmd_acc  = cmd.valid && cmd.ready;
  assign cmd_func = func_t'(cmd.func);

  assign rd_t = rd_data[2*DATA_W-1:DATA_W];
  assign rd_v = rd_data[DATA_W-1:0];

  assign scan_last = (COUNT_W'(ai) == n_use - COUNT_W'(1));
  assign scan_stop = qle || scan_last || (qt < rd_t);

  assign at_sel = anchor_cur ? cur_t : prev_t;
  assign av_sel = anchor_cur ? cur_v : prev_v;
  assign dt     = {cur_t[DATA_W-1], cur_t} - {prev_t[DATA_W-1], prev_t};
  assign dv     = {cur_v[DATA_W-1], cur_v} - {prev_v[DATA_W-1], prev_v};
  assign dq     = {qt[DATA_W-1], qt} - {at_sel[DATA_W-1], at_sel};

  assign av_x    = {{(SUM_W-DATA_W){av[DATA_W-1]}}, av};
  assign q_x     = {{(SUM_W-QUOT_W){1'b0}}, quot};
  assign sum     = neg ? av_x - q_x : av_x + q_x;
  assign sum_ovf = (sum[SUM_W-1:DATA_W-1] != '0) && (sum[SUM_W-1:DATA_W-1] != '1);

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[cmd.entry_index] <= {cmd.entry_time, cmd.entry_value};
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          case (cmd_func)
            FUNC_WRITE:  state_next = S_EMIT;
            FUNC_READ:   state_next = (COUNT_W'(cmd.entry_index) < n_use) ? S_RDATA : S_EMIT;
            FUNC_INTERP: state_next = (n_use == '0) ? S_EMIT : S_T0;
            default:     state_next = S_EMIT;
          endcase
        end
      end
      S_T0:    state_next = (n_use == COUNT_W'(1)) ? S_EMIT : S_SCAN;
      S_SCAN:  if (scan_stop) state_next = S_DIFF;
      S_DIFF:  state_next = (dt == '0) ? S_EMIT : S_MD;
      S_MD:    if (md_rsp.done) state_next = S_SUM;
      S_SUM:   state_next = S_EMIT;
      S_RDATA: state_next = S_EMIT;
      S_EMIT:  if (!out_valid || res.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready    = (state == S_IDLE);
    mem_we       = cmd_acc && (cmd_func == FUNC_WRITE);
    load_out     = (state == S_EMIT) && (!out_valid || res.ready);
    md_req.start = (state == S_DIFF) && (dt != '0);
    md_req.a     = mag(dq);
    md_req.b     = mag(dv);
    md_req.d     = mag(dt);
    case (state)
      S_IDLE:  rd_addr = (cmd_func == FUNC_READ) ? cmd.entry_index : '0;
      S_T0:    rd_addr = ADDR_W'(1);
      S_SCAN:  rd_addr = ai + ADDR_W'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) entry_count <= cfg_wr_data;
      if (load_out) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value  <= pend_value;
      out_time   <= pend_time;
      out_status <= pend_status;
    end
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          qt         <= cmd.query_time;
          pend_value <= '0;
          pend_time  <= '0;
          case (cmd_func)
            FUNC_WRITE:  pend_status <= ST_OK;
            FUNC_READ:   pend_status <= (COUNT_W'(cmd.entry_index) < n_use) ? ST_OK : ST_RANGE;
            FUNC_INTERP: pend_status <= (n_use != '0) ? ST_OK : ST_RANGE;
            default:     pend_status <= ST_RANGE;
          endcase
        end
      end
      S_T0: begin
        prev_t     <= rd_t;
        prev_v     <= rd_v;
        qle        <= (qt <= rd_t);
        ai         <= ADDR_W'(1);
        pend_value <= rd_v;
      end
      S_SCAN: begin
        if (scan_stop) begin
          cur_t      <= rd_t;
          cur_v      <= rd_v;
          // past the first breakpoint and on the last segment: anchor at its end
          anchor_cur <= !qle && scan_last;
        end else begin
          prev_t <= rd_t;
          prev_v <= rd_v;
          ai     <= ai + ADDR_W'(1);
        end
      end
      S_DIFF: begin
        av          <= av_sel;
        neg         <= dq[DIFF_W-1] ^ dv[DIFF_W-1] ^ dt[DIFF_W-1];
        pend_value  <= av_sel;
        pend_status <= ST_ZERO_WIDTH;
      end
      S_MD: begin
        if (md_rsp.done) begin
          quot <= md_rsp.quot;
          big  <= md_rsp.big;
        end
      end
      S_SUM: begin
        if (big) begin
          pend_value  <= neg ? SAT_MIN : SAT_MAX;
          pend_status <= ST_SAT;
        end else if (sum_ovf) begin
          pend_value  <= sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
          pend_status <= ST_SAT;
        end else begin
          pend_value  <= sum[DATA_W-1:0];
          pend_status <= ST_OK;
        end
      end
      S_RDATA: begin
        pend_value  <= rd_v;
        pend_time   <= rd_t;
        pend_status <= ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign res.valid        = out_valid;
  assign res.result_value = out_value;
  assign res.result_time  = out_time;
  assign res.status       = out_status;

  a_done_in_md: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> state == S_MD)
    else $error("muldiv finished outside the wait state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (COUNT_W'(ai) < n_use) && (n_use >= COUNT_W'(2)))
    else $error("scan index beyond the table");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && !res.ready) |=> (state == S_EMIT && out_valid))
    else $error("pending result dropped while output stalled");

  a_write_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && cmd_func == FUNC_WRITE) |=> (state == S_EMIT && pend_status == ST_OK))
    else $error("write transaction did not go straight to emit");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the piecewise linear interpolator: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
  import pli_pkg::*;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS  = 1400;
  localparam int         DRAIN_CYCLES  = 300;
  localparam longint     QUOT_LIMIT    = 64'sd1 << 40;
  localparam longint     INT32_MAX     = 64'sd2147483647;
  localparam longint     INT32_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]               func;
    logic [ADDR_W-1:0]        entry_index;
    logic signed [DATA_W-1:0] entry_time;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] query_time;
  } cmd_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic signed [DATA_W-1:0] result_time;
    logic [1:0]               status;
  } result_item_t;

  typedef struct packed {
    logic               is_cfg;
    logic [COUNT_W-1:0] count;
    cmd_item_t          cmd;
    logic               typed;
    result_item_t       res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  pli_cmd_if cmd_ch ();
  pli_res_if res_ch ();

  piecewise_linear_interpolator uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .res         (res_ch)
  );

  // Predicted breakpoint table and count
  logic signed [DATA_W-1:0] bp_time  [TABLE_DEPTH];
  logic signed [DATA_W-1:0] bp_value [TABLE_DEPTH];
  logic [COUNT_W-1:0]       bp_count = '0;

  result_item_t pending_results [$];
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;

  dir_row_t directed_rows [24] = '{
    '{1'b0, 7'd0, '{FUNC_INTERP, 6'd0, 32'h0, 32'h0, 32'h1234_5678}, 1'b1,
      '{32'h0, 32'h0, ST_RANGE}},
    '{1'b0, 7'd0, '{FUNC_READ, 6'd0, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{32'h0, 32'h0, ST_RANGE}},
    '{1'b0, 7'd0, '{FUNC_UNUSED, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{32'h0, 32'h0, ST_RANGE}},
    '{1'b0, 7'd0, '{FUNC_WRITE, 6'd0, 32'h0, 32'h7FFF_FFFF, 32'h0}, 1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0, '{FUNC_WRITE, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0}, 1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b1, 7'd1, '0, 1'b0, '0},
    '{1'b0, 7'd0, '{FUNC_INTERP, 6'd0, 32'h0, 32'h0, 32'h8000_0000}, 1'b1,
      '{32'h7FFF_FFFF, 32'h0, ST_OK}},
    '{1'b0, 7'd0, '{FUNC_READ, 6'd0, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{32'h7FFF_FFFF, 32'h0, ST_OK}},
    '{1'b0, 7'd0, '{FUNC_READ, 6'd1, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{32'h0, 32'h0, ST_RANGE}},
    '{1'b0, 7'd0, '{FUNC_WRITE, 6'd1, 32'h0001_0000, 32'h8000_0000, 32'h0}, 1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b1, 7'd2, '0, 1'b0, '0},
    '{1'b0, 7'd0, '{FUNC_INTERP, 6'd0, 32'h0, 32'h0, 32'h8000_0000}, 1'b0, '0},
    '{1'b0, 7'd0, '{FUNC_INTERP, 6'd0, 32'h0, 32'h0, 32'h0000_8000}, 1'b0, '0},
    '{1'b0, 7'd0, '{FUNC_INTERP, 6'd0, 32'h0, 32'h0, 32'h7FFF_FFFF}, 1'b0, '0},
    '{1'b0, 7'd0, '{FUNC_WRITE, 6'd1, 32'h0, 32'h5, 32'h0}, 1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0, '{FUNC_INTERP, 6'd0, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{32'h7FFF_FFFF, 32'h0, ST_ZERO_WIDTH}},
    '{1'b0, 7'd0, '{FUNC_INTERP, 6'd0, 32'h0, 32'h0, 32'h1234_5678}, 1'b1,
      '{32'h5, 32'h0, ST_ZERO_WIDTH}},
    '{1'b0, 7'd0, '{FUNC_WRITE, 6'd2, 32'h0002_0000, 32'h0001_0000, 32'h0}, 1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b0, 7'd0, '{FUNC_WRITE, 6'd1, 32'h0001_0000, 32'h0, 32'h0}, 1'b1,
      '{32'h0, 32'h0, ST_OK}},
    '{1'b1, 7'd3, '0, 1'b0, '0},
    '{1'b0, 7'd0, '{FUNC_INTERP, 6'd0, 32'h0, 32'h0, 32'h0001_8000}, 1'b0, '0},
    '{1'b0, 7'd0, '{FUNC_INTERP, 6'd0, 32'h0, 32'h0, 32'hFFFF_0000}, 1'b0, '0},
    '{1'b1, 7'd64, '0, 1'b0, '0},
    '{1'b0, 7'd0, '{FUNC_READ, 6'd63, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{32'h8000_0000, 32'h7FFF_FFFF, ST_OK}}
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one transaction to the predicted table and return its result
  function automatic result_item_t table_response(input cmd_item_t c);
    result_item_t r;
    int           n, u, a;
    longint       dq, dv, dt, mdq, mdv, mdt, sum;
    logic [127:0] quot;
    bit           neg;
    r = '0;
    n = (bp_count < TABLE_DEPTH) ? int'(bp_count) : TABLE_DEPTH;
    case (c.func)
      FUNC_WRITE: begin
        bp_time[c.entry_index]  = c.entry_time;
        bp_value[c.entry_index] = c.entry_value;
      end
      FUNC_READ: begin
        if (int'(c.entry_index) < n) begin
          r.result_time  = bp_time[c.entry_index];
          r.result_value = bp_value[c.entry_index];
        end else begin
          r.status = ST_RANGE;
        end
      end
      FUNC_INTERP: begin
        if (n == 0) begin
          r.status = ST_RANGE;
        end else if (n == 1) begin
          r.result_value = bp_value[0];
        end else begin
          u = 1;
          if (c.query_time > bp_time[0]) begin
            u = n - 1;
            for (int k = 1; k < n - 1; k++) begin
              if (c.query_time < bp_time[k]) begin
                u = k;
                break;
              end
            end
          end
          // Past the first breakpoint and on the last segment, anchor on the far end of the segment
          a  = (c.query_time > bp_time[0] && u == n - 1) ? u : u - 1;
          dq = longint'(c.query_time) - longint'(bp_time[a]);
          dv = longint'(bp_value[u]) - longint'(bp_value[u-1]);
          dt = longint'(bp_time[u]) - longint'(bp_time[u-1]);
          if (dt == 0) begin
            r.result_value = bp_value[a];
            r.status       = ST_ZERO_WIDTH;
          end else begin
            neg  = ((dq < 0) != (dv < 0)) != (dt < 0);
            mdq  = (dq < 0) ? -dq : dq;
            mdv  = (dv < 0) ? -dv : dv;
            mdt  = (dt < 0) ? -dt : dt;
            quot = (128'(mdq) * 128'(mdv)) / 128'(mdt);
            if (quot > 128'(QUOT_LIMIT)) begin
              r.result_value = neg ? SAT_MIN : SAT_MAX;
              r.status       = ST_SAT;
            end else begin
              sum = neg ? longint'(bp_value[a]) - longint'(quot[63:0])
                        : longint'(bp_value[a]) + longint'(quot[63:0]);
              if (sum > INT32_MAX) begin
                r.result_value = SAT_MAX;
                r.status       = ST_SAT;
              end else if (sum < INT32_MIN) begin
                r.result_value = SAT_MIN;
                r.status       = ST_SAT;
              end else begin
                r.result_value = sum[31:0];
              end
            end
          end
        end
      end
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  // Random transaction against a loaded table of n breakpoints
  function automatic cmd_item_t random_cmd(input int n);
    cmd_item_t c;
    int        pick, k;
    longint    q;
    c.entry_index = 6'($urandom_range(0, TABLE_DEPTH - 1));
    c.entry_time  = $urandom;
    c.entry_value = $urandom;
    c.query_time  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      c.func = FUNC_INTERP;
      if (n > 0) begin
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 4))
          0: q = bp_time[k];
          1: q = longint'(bp_time[k]) + longint'($urandom_range(0, 32'h0004_0000)) - 64'sd131072;
          2: q = c.query_time;
          3: q = longint'(bp_time[0]) - longint'($urandom_range(0, 32'h0100_0000));
          default: q = longint'(bp_time[n-1]) + longint'($urandom_range(0, 32'h0100_0000));
        endcase
        if (q > INT32_MAX) q = INT32_MAX;
        else if (q < INT32_MIN) q = INT32_MIN;
        c.query_time = q[31:0];
      end
    end else if (pick < 80) begin
      c.func = FUNC_READ;
      if (n > 0 && $urandom_range(0, 1) == 0) c.entry_index = 6'($urandom_range(0, n - 1));
    end else if (pick < 93) begin
      c.func = FUNC_WRITE;
    end else begin
      c.func = FUNC_UNUSED;
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("ERROR at %0t: %s got %h, expected %h", $time, what, seen, wanted);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_cmd(input cmd_item_t c, input bit typed, input result_item_t typed_res);
    result_item_t want;
    while ($urandom_range(1, 100) <= send_idle_pct) @(negedge clk);
    cmd_ch.valid       = 1'b1;
    cmd_ch.func        = c.func;
    cmd_ch.entry_index = c.entry_index;
    cmd_ch.entry_time  = c.entry_time;
    cmd_ch.entry_value = c.entry_value;
    cmd_ch.query_time  = c.query_time;
    do @(posedge clk); while (!cmd_ch.ready);
    want = table_response(c);
    pending_results.insert(pending_results.size(), typed ? typed_res : want);
    items_sent++;
    @(negedge clk);
    cmd_ch.valid = 1'b0;
  endtask

  // Hold off until every result is back, then write the count register
  task automatic set_count(input logic [COUNT_W-1:0] count);
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = count;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    bp_count  = count;
  endtask

  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(1, 100) > stall_pct);
  end

  always @(posedge clk) begin : check_results
    result_item_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.result_value, res_ch.result_time, res_ch.status};
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, result_value", got.result_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.result_value !== want.result_value)
          report_mismatch("result_value", got.result_value, want.result_value);
        if (got.result_time !== want.result_time)
          report_mismatch("result_time", got.result_time, want.result_time);
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
      end
    end
  end

  initial begin
    int                       phase, n, k;
    bit                       wide;
    logic signed [DATA_W-1:0] times [$];
    cmd_item_t                c;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.func        = '0;
    cmd_ch.entry_index = '0;
    cmd_ch.entry_time  = '0;
    cmd_ch.entry_value = '0;
    cmd_ch.query_time  = '0;
    res_ch.ready       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        set_count(directed_rows[i].count);
      else
        send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
    end

    phase = 0;
    while (items_sent < RANDOM_ITEMS + $size(directed_rows)) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      case (phase % 6)
        0: n = 2;
        1: n = TABLE_DEPTH;
        2: n = 1;
        3: n = 0;
        default: n = $urandom_range(3, 12);
      endcase
      set_count(COUNT_W'(n));

      // Load an ascending table, sometimes with a repeated time
      wide = ($urandom_range(0, 2) == 0);
      times.delete();
      for (k = 0; k < n; k++)
        times.insert(times.size(),
                     wide ? $urandom : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
      times.sort();
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, n - 1);
        times[k] = times[k-1];
      end
      for (k = 0; k < n; k++) begin
        c.func        = FUNC_WRITE;
        c.entry_index = 6'(k);
        c.entry_time  = times[k];
        c.entry_value = wide ? $urandom : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        c.query_time  = $urandom;
        send_cmd(c, 1'b0, '0);
      end

      repeat ($urandom_range(20, 60)) send_cmd(random_cmd(n), 1'b0, '0);
      phase++;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pli_pkg.sv
design/pli_if.sv
design/pli_muldiv.sv
design/piecewise_linear_interpolator.sv
tb/testbench.sv
